// ----- hdl/lpcd_pkg.sv -----
// shared types, constants and the crc-16/modbus byte update for the deframer
// no dependencies
package lpcd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic REG_SOF_BYTE   = 1'b0;
  localparam logic REG_CRC_ENABLE = 1'b1;

  localparam logic [7:0] SOF_BYTE_RST   = 8'd2;
  localparam logic       CRC_ENABLE_RST = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_CRC_BAD   = 2'd1,
    ST_TOO_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       frame_end;
    status_t    frame_status;
  } result_t;

  // reflected crc, one byte: eight shift/xor steps on a 16-bit value
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/lpcd_crc.sv -----
// crc-16/modbus update of the running value by one received word
// depends on lpcd_pkg
module lpcd_crc
  import lpcd_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  assign crc_out = crc16_byte(crc_in, data_in);

endmodule

// ----- hdl/lpcd_parser.sv -----
// frame parser: start hunt, length header, body count, crc check and two-word delay
// depends on lpcd_pkg and lpcd_crc
module lpcd_parser
  import lpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] sof_byte,
  input  logic       crc_enable,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_upd;
  logic [7:0]  dly0_r, dly0_nxt;
  logic [7:0]  dly1_r, dly1_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        last;
  logic        popped_has;

  lpcd_crc u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_hi_r <= '0;
      remain_r <= '0;
      crc_r    <= CRC_INIT;
      dly0_r   <= '0;
      dly1_r   <= '0;
      fill_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      remain_r <= remain_nxt;
      crc_r    <= crc_nxt;
      dly0_r   <= dly0_nxt;
      dly1_r   <= dly1_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    remain_nxt = remain_r;
    crc_nxt    = crc_r;
    dly0_nxt   = dly0_r;
    dly1_nxt   = dly1_r;
    fill_nxt   = fill_r;
    res_valid  = 1'b0;
    res        = '0;
    last       = (remain_r == 16'd1);
    popped_has = 1'b0;
    if (byte_take) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == sof_byte) phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_nxt = rx_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          remain_nxt = {len_hi_r, rx_byte};
          crc_nxt    = CRC_INIT;
          dly0_nxt   = '0;
          dly1_nxt   = '0;
          fill_nxt   = '0;
          if ({len_hi_r, rx_byte} == 16'd0) begin
            // empty frame: bare end marker
            phase_nxt        = PH_HUNT;
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.frame_status = crc_enable ? ST_TOO_SHORT : ST_GOOD;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          remain_nxt = remain_r - 16'd1;
          if (last) phase_nxt = PH_HUNT;
          if (!crc_enable) begin
            res_valid        = 1'b1;
            res.payload_byte = rx_byte;
            res.has_byte     = 1'b1;
            res.frame_end    = last;
          end else begin
            crc_nxt = crc_upd;
            if (fill_r >= 2'd2) begin
              popped_has = 1'b1;
              dly0_nxt   = dly1_r;
              dly1_nxt   = rx_byte;
            end else if (fill_r == 2'd1) begin
              dly1_nxt = rx_byte;
              fill_nxt = 2'd2;
            end else begin
              dly0_nxt = rx_byte;
              fill_nxt = 2'd1;
            end
            res.payload_byte = popped_has ? dly0_r : 8'd0;
            res.has_byte     = popped_has;
            if (last) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              if (fill_r == 2'd0) begin
                res.frame_status = ST_TOO_SHORT;
              end else begin
                res.frame_status = (crc_upd == 16'd0) ? ST_GOOD : ST_CRC_BAD;
              end
            end else begin
              res_valid = popped_has;
            end
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

endmodule

// ----- hdl/length_prefixed_crc_deframer.sv -----
// top level of the length-prefixed crc-16/modbus deframer
// depends on lpcd_pkg and lpcd_parser
//
//  channel  ports                                   direction  per word
//  in       in_valid/in_ready, in_rx_byte           input      one received byte
//  out      out_valid/out_ready, out_payload_byte,  output     zero or one result
//           out_has_byte, out_frame_end, out_frame_status
//  cfg      cfg_we, cfg_index, cfg_data             input      one register write
//
// one word per cycle unless stalled: the parser updates its state in the cycle
// a word is taken and the result lands in the output register on the same edge
// the output register frees up in the cycle it is read, so in_ready stays high
// under continuous flow; it drops only while a result waits with out_ready low
// synchronous active-low reset: hunting for start byte, start byte 2, crc on
module length_prefixed_crc_deframer
  import lpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // received words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic       out_frame_end,
  output logic [1:0] out_frame_status
);

  logic [7:0] sof_byte_r;
  logic       crc_enable_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  logic       take;
  logic       res_valid;
  result_t    res;

  // configuration registers: the user writes them only while idle; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_byte_r   <= SOF_BYTE_RST;
      crc_enable_r <= CRC_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOF_BYTE:   sof_byte_r   <= cfg_data;
        REG_CRC_ENABLE: crc_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // accept whenever the output register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  lpcd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .sof_byte   (sof_byte_r),
    .crc_enable (crc_enable_r),
    .byte_take  (take),
    .rx_byte    (in_rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register: loads a new result or clears once the old one is read
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_has_byte     = out_res_r.has_byte;
  assign out_frame_end    = out_res_r.frame_end;
  assign out_frame_status = out_res_r.frame_status;

endmodule

// ----- tb/sv/deframe_checker.sv -----
`timescale 1ns / 1ps
// result checker for the length-prefixed crc deframer: watches every handshake,
// predicts the results and compares them; depends on lpcd_pkg
module deframe_checker
  import lpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_payload_byte,
  input  logic       out_has_byte,
  input  logic       out_frame_end,
  input  logic [1:0] out_frame_status,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  // predicted register and parser state
  logic [7:0]  start_sel;
  logic        crc_on;
  phase_t      phase;
  logic [7:0]  len_hi;
  logic [15:0] remaining;
  logic [15:0] crc_acc;
  logic [7:0]  held [2];
  logic [1:0]  held_cnt;

  result_t expected_results[$];
  int      errors;
  int      compared;

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] v;
    v = acc ^ {8'h00, d};
    repeat (8) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic void queue_result(input logic [7:0] d, input logic has, input logic fin,
                                       input status_t st);
    result_t r;
    r.payload_byte = d;
    r.has_byte     = has;
    r.frame_end    = fin;
    r.frame_status = st;
    expected_results.push_back(r);
  endfunction

  task automatic advance_parser(input logic [7:0] b);
    logic       last;
    logic       popped_ok;
    logic [7:0] popped;
    status_t    st;
    case (phase)
      PH_HUNT: begin
        if (b == start_sel) phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_hi = b;
        phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        remaining = {len_hi, b};
        crc_acc   = CRC_INIT;
        held[0]   = 8'h00;
        held[1]   = 8'h00;
        held_cnt  = 2'd0;
        if (remaining == 16'd0) begin
          phase = PH_HUNT;
          queue_result(8'h00, 1'b0, 1'b1, crc_on ? ST_TOO_SHORT : ST_GOOD);
        end else begin
          phase = PH_BODY;
        end
      end
      default: begin
        remaining = remaining - 16'd1;
        last      = (remaining == 16'd0);
        if (last) phase = PH_HUNT;
        if (!crc_on) begin
          queue_result(b, 1'b1, last, ST_GOOD);
        end else begin
          crc_acc   = modbus_crc_step(crc_acc, b);
          popped    = 8'h00;
          popped_ok = 1'b0;
          // two-word delay keeps the trailing crc from ever coming out
          if (held_cnt == 2'd2) begin
            popped    = held[0];
            popped_ok = 1'b1;
            held[0]   = held[1];
            held[1]   = b;
          end else if (held_cnt == 2'd1) begin
            held[1]  = b;
            held_cnt = 2'd2;
          end else begin
            held[0]  = b;
            held_cnt = 2'd1;
          end
          if (last) begin
            if (!popped_ok && held_cnt == 2'd1) st = ST_TOO_SHORT;
            else st = (crc_acc == 16'd0) ? ST_GOOD : ST_CRC_BAD;
            queue_result(popped, popped_ok, 1'b1, st);
          end else if (popped_ok) begin
            queue_result(popped, 1'b1, 1'b0, ST_GOOD);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      start_sel = SOF_BYTE_RST;
      crc_on    = CRC_ENABLE_RST;
      phase     = PH_HUNT;
      len_hi    = 8'h00;
      remaining = 16'd0;
      crc_acc   = CRC_INIT;
      held[0]   = 8'h00;
      held[1]   = 8'h00;
      held_cnt  = 2'd0;
      expected_results.delete();
      errors    = 0;
      compared  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SOF_BYTE) start_sel = cfg_data;
        else if (cfg_index == REG_CRC_ENABLE) crc_on = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: payload_byte %02h has_byte %0b frame_end %0b status %0d",
                 out_payload_byte, out_has_byte, out_frame_end, out_frame_status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compared++;
          if (out_payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %02h, actual %02h", want.payload_byte,
                   out_payload_byte);
            errors++;
          end
          if (out_has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, actual %0b", want.has_byte, out_has_byte);
            errors++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
            errors++;
          end
          if (out_frame_status !== want.frame_status) begin
            $error("frame_status: expected %0d, actual %0d", want.frame_status,
                   out_frame_status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) advance_parser(in_rx_byte);
    end
    fail_count <= errors;
    pending    <= expected_results.size();
    checked    <= compared;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, word and register stimulus, verdict
// depends on lpcd_pkg, length_prefixed_crc_deframer and deframe_checker
module tb;
  import lpcd_pkg::*;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic       cfg_index  = REG_SOF_BYTE;
  logic [7:0] cfg_data   = 8'h00;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_has_byte;
  logic       out_frame_end;
  logic [1:0] out_frame_status;

  // random idling on both sides, switched off for one stretch
  logic gaps_on   = 1'b1;
  // asks the receiver for one long hold-off
  logic stall_req = 1'b0;
  int   stall_left = 0;

  int bytes_sent  = 0;
  int frames_sent = 0;
  int fail_count;
  int pending;
  int checked;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  length_prefixed_crc_deframer dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_rx_byte,
    .out_valid, .out_ready, .out_payload_byte, .out_has_byte, .out_frame_end,
    .out_frame_status
  );

  deframe_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_rx_byte,
    .out_valid, .out_ready, .out_payload_byte, .out_has_byte, .out_frame_end,
    .out_frame_status,
    .fail_count, .pending, .checked
  );

  // receiver: random back-pressure, or a long hold-off counted here in cycles
  always @(posedge clk) begin
    if (stall_req) begin
      stall_req  <= 1'b0;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !gaps_on || ($urandom_range(0, 99) >= 25);
    end
  end

  // offer one word, idling at random first; returns at the edge that takes it
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // sender goes quiet until every predicted result is out, then idles on for spare
  // cycles, since the block holds at most one result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, written back to back while the block is idle
  task automatic set_config(input logic [7:0] sof, input logic crc_mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOF_BYTE;
    cfg_data  <= sof;
    @(posedge clk);
    cfg_index <= REG_CRC_ENABLE;
    cfg_data  <= {7'd0, crc_mode};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one frame: start word, big-endian length, body; with crc and a body of two or
  // more words the last two body words are the crc-16/modbus of the payload, low word first
  // len_skew makes the declared length lie, corrupt flips one bit of the body
  task automatic send_frame(input logic [7:0] sof, input int body_len, input logic with_crc,
                            input int len_skew, input logic corrupt);
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          declared;
    int          payload_len;
    payload_len = (with_crc && body_len >= 2) ? body_len - 2 : body_len;
    crc = CRC_INIT;
    for (int k = 0; k < payload_len; k++) begin
      // start word inside a body is plain data, but keep it out of frames
      // whose length lies so that the hunt afterwards stays on track
      b = 8'($urandom_range(0, 255));
      if (len_skew == 0 && $urandom_range(0, 9) == 0) b = sof;
      else if (len_skew != 0 && b == sof) b = ~b;
      body.push_back(b);
      crc = crc16_byte(crc, b);
    end
    if (payload_len != body_len) begin
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    if (corrupt && body.size() > 0)
      body[$urandom_range(0, body.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    declared = body_len + len_skew;
    if (declared < 0) declared = 0;
    send_byte(sof);
    send_byte(declared[15:8]);
    send_byte(declared[7:0]);
    foreach (body[k]) send_byte(body[k]);
    frames_sent++;
  endtask

  // mostly well-formed frames with random content, some stray words, some
  // crc errors when crc is on and a few frames whose length is off by one or two
  task automatic run_phase(input logic [7:0] sof, input logic crc_mode, input int budget);
    int         stop_at;
    int         pick;
    int         len;
    int         skew;
    logic [7:0] junk;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 3)) begin
          junk = 8'($urandom_range(0, 255));
          if (junk == sof) junk = ~junk;
          send_byte(junk);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) len = $urandom_range(0, 3);
      else if (pick < 90) len = $urandom_range(4, 16);
      else if (pick < 99) len = $urandom_range(17, 64);
      else len = $urandom_range(256, 272);
      skew = ($urandom_range(0, 99) < 4) ? int'($urandom_range(0, 4)) - 2 : 0;
      send_frame(sof, len, crc_mode, skew, crc_mode && ($urandom_range(0, 99) < 12));
      // an overlong frame eats these instead of the next header
      if (skew != 0) begin
        repeat (2) begin
          junk = 8'($urandom_range(0, 255));
          if (junk == sof) junk = ~junk;
          send_byte(junk);
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on reset settings: start word 2, crc on
    send_byte(8'h00);                                  // stray words while hunting
    send_byte(8'hFF);
    send_frame(SOF_BYTE_RST, 0, 1'b1, 0, 1'b0);        // zero length: empty end, too short
    send_frame(SOF_BYTE_RST, 1, 1'b1, 0, 1'b0);        // one-word body: too short
    send_frame(SOF_BYTE_RST, 2, 1'b1, 0, 1'b0);        // crc only, good
    send_frame(SOF_BYTE_RST, 2, 1'b1, 0, 1'b1);        // crc only, bad
    send_frame(SOF_BYTE_RST, 4, 1'b1, 0, 1'b0);        // two payload words, good
    send_frame(SOF_BYTE_RST, 4, 1'b1, 0, 1'b1);        // two payload words, bad crc

    // random phases over several settings, extremes of the start word among them
    drain();
    run_phase(SOF_BYTE_RST, CRC_ENABLE_RST, 220);

    // crc off: every body word comes out, so a long receiver hold-off fills
    // the output register and stalls the input while words keep coming
    set_config(8'h00, 1'b0);
    stall_req <= 1'b1;
    run_phase(8'h00, 1'b0, 250);

    // a stretch without any idling on either side
    set_config(8'hFF, 1'b1);
    gaps_on <= 1'b0;
    run_phase(8'hFF, 1'b1, 250);
    gaps_on <= 1'b1;

    set_config(8'h7E, 1'b1);
    run_phase(8'h7E, 1'b1, 250);

    set_config(8'hA5, 1'b0);
    run_phase(8'hA5, 1'b0, 250);

    begin : random_settings
      logic [7:0] sof;
      logic       mode;
      repeat (2) begin
        sof  = 8'($urandom_range(0, 255));
        mode = 1'($urandom_range(0, 1));
        set_config(sof, mode);
        run_phase(sof, mode, 250);
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d words in %0d frames, %0d results checked", bytes_sent,
             frames_sent, checked);
    $display("start words 00/02/7E/A5/FF and random, crc on and off, short and bad frames");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
